/* rtl/vsc_pkg.sv */
// Shared types, constants and helpers of the Verlet step core.
`timescale 1ns / 1ps

package vsc_pkg;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_GRAVITY_X      = 3'd0;
    localparam logic [2:0] REG_GRAVITY_Y      = 3'd1;
    localparam logic [2:0] REG_TIME_STEP      = 3'd2;
    localparam logic [2:0] REG_BOUND_CENTER_X = 3'd3;
    localparam logic [2:0] REG_BOUND_CENTER_Y = 3'd4;
    localparam logic [2:0] REG_BOUND_RADIUS   = 3'd5;
    localparam logic [2:0] REG_BOUNCE_MODE    = 3'd6;

    // Reset values: 640.0, 360.0 and 300.0 in Q16.16, dt of about 1/60 s
    localparam logic signed [31:0] RST_CENTER_X  = 32'sd41943040;
    localparam logic signed [31:0] RST_CENTER_Y  = 32'sd23592960;
    localparam logic [30:0]        RST_RADIUS    = 31'd19660800;
    localparam logic [15:0]        RST_TIME_STEP = 16'd1092;

    localparam int SQ_STEPS  = 32;  // one root bit per stage
    localparam int DIV_STEPS = 33;  // one quotient bit per stage
    // front (3) + root (33) + scale (1) + divide (34) + correction/Verlet (8)
    localparam int NSTAGE    = 79;
    localparam int IN_W      = 224;
    localparam int OUT_W     = 136;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] limit;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic               neg_x;
        logic               neg_y;
        logic               sh;
        logic [32:0]        radial;
        logic               hit;
    } carry_t;

    typedef struct packed {
        logic [33:0] rem;
        logic [63:0] num;
        logic [32:0] quo;
    } div_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] prev_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] cur_y;
        logic signed [31:0] cur_x;
    } out_t;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > 48'sh0000_7fff_ffff) begin
            r = 32'sh7fff_ffff;
        end else if (v < 48'shffff_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/verlet_step_circular_bound_core.sv */
// Verlet particle step with circular boundary correction, fully pipelined.
`timescale 1ns / 1ps

// One particle enters per clock while s_tready is high; its result is offered
// on m_tdata from the output register, which follows 79 pipeline registers
// (the first loaded by the accepting edge). The rate is one item a cycle
// while no stall holds the pipeline. Its depth is set by the square root
// (one root bit per stage, 32 stages) and the four dividers for the boundary
// scale and the normal (one quotient bit per stage, 33 stages).
// A stall at m_tready lets the pipeline keep advancing until a second
// transaction reaches the held output; a one-deep skid register catches that
// one and the whole pipeline then freezes, so s_tready is registered.
// Configuration writes are always taken (cfg_ready is tied high) and are
// meant for times when the pipeline is empty.
module verlet_step_circular_bound_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    // cur_x, cur_y, prev_x, prev_y, particle_radius, pending_ax, pending_ay
    input  logic [vsc_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // new_cur_x, new_cur_y, new_prev_x, new_prev_y, hit_bound
    output logic [vsc_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data
);

    localparam int N = vsc_pkg::NSTAGE;

    // ---------------- configuration registers ----------------
    logic signed [31:0] gx_reg, gy_reg, cx_reg, cy_reg;
    logic [15:0]        dt_reg;
    logic [30:0]        br_reg;
    logic               bounce_reg;
    logic [31:0]        dt2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_reg     <= '0;
            gy_reg     <= '0;
            dt_reg     <= vsc_pkg::RST_TIME_STEP;
            cx_reg     <= vsc_pkg::RST_CENTER_X;
            cy_reg     <= vsc_pkg::RST_CENTER_Y;
            br_reg     <= vsc_pkg::RST_RADIUS;
            bounce_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vsc_pkg::REG_GRAVITY_X:      gx_reg     <= cfg_data;
                vsc_pkg::REG_GRAVITY_Y:      gy_reg     <= cfg_data;
                vsc_pkg::REG_TIME_STEP:      dt_reg     <= cfg_data[15:0];
                vsc_pkg::REG_BOUND_CENTER_X: cx_reg     <= cfg_data;
                vsc_pkg::REG_BOUND_CENTER_Y: cy_reg     <= cfg_data;
                vsc_pkg::REG_BOUND_RADIUS:   br_reg     <= cfg_data[30:0];
                vsc_pkg::REG_BOUNCE_MODE:    bounce_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // dt squared, Q0.32; settles long before any item reaches its use
    always_ff @(posedge aclk) begin
        dt2_reg <= 32'(dt_reg) * 32'(dt_reg);
    end

    // ---------------- flow control ----------------
    logic           en;
    logic [N-1:0]   valid_reg;
    logic           m_valid_reg, skid_valid_reg;
    vsc_pkg::out_t  last_data, m_data_reg, skid_data_reg;

    // advance the pipeline unless the skid register holds a transaction
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (en) begin
                valid_reg <= {valid_reg[N-2:0], s_tvalid};
            end
            if (m_valid_reg && !m_tready) begin
                // output held: park the arriving transaction
                if (en && valid_reg[N-1]) begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else if (en) begin
                m_valid_reg <= valid_reg[N-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && !m_tready) begin
            if (en && valid_reg[N-1]) begin
                skid_data_reg <= last_data;
            end
        end else if (skid_valid_reg) begin
            m_data_reg <= skid_data_reg;
        end else if (en) begin
            m_data_reg <= last_data;
        end
    end

    // ---------------- stage 1: offsets, acceleration, limit ----------------
    logic signed [31:0] in_cur_x, in_cur_y, in_pax, in_pay;
    logic [26:0]        in_pr;
    vsc_pkg::carry_t    c1_next, c1_reg, c2_reg, c3_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic signed [31:0] ax1_reg, ay1_reg;

    assign in_cur_x = s_tdata[31:0];
    assign in_cur_y = s_tdata[63:32];
    assign in_pr    = s_tdata[154:128];
    assign in_pax   = s_tdata[186:155];
    assign in_pay   = s_tdata[218:187];

    always_comb begin
        c1_next        = '0;
        c1_next.cur_x  = in_cur_x;
        c1_next.cur_y  = in_cur_y;
        c1_next.prev_x = s_tdata[95:64];
        c1_next.prev_y = s_tdata[127:96];
        c1_next.limit  = $signed({1'b0, br_reg}) - $signed({5'b0, in_pr});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg  <= c1_next;
            dx1_reg <= 33'(in_cur_x) - 33'(cx_reg);
            dy1_reg <= 33'(in_cur_y) - 33'(cy_reg);
            ax1_reg <= vsc_pkg::sat32(48'(in_pax) + 48'(gx_reg));
            ay1_reg <= vsc_pkg::sat32(48'(in_pay) + 48'(gy_reg));
        end
    end

    // ---------------- stage 2: magnitudes, pre-scaling ----------------
    logic [32:0]     mx1, my1;
    logic            sh1;
    vsc_pkg::carry_t c2_next;
    logic [30:0]     hx2_reg, hy2_reg;
    logic [31:0]     am2x_reg, am2y_reg;
    logic            an2x_reg, an2y_reg;

    assign mx1 = 33'(dx1_reg[32] ? -dx1_reg : dx1_reg);
    assign my1 = 33'(dy1_reg[32] ? -dy1_reg : dy1_reg);
    // halve both offsets when either reaches 2^31 so the squares fit
    assign sh1 = mx1[31] | my1[31];

    always_comb begin
        c2_next       = c1_reg;
        c2_next.mx    = mx1[31:0];
        c2_next.my    = my1[31:0];
        c2_next.neg_x = dx1_reg[32];
        c2_next.neg_y = dy1_reg[32];
        c2_next.sh    = sh1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c2_reg   <= c2_next;
            hx2_reg  <= sh1 ? mx1[31:1] : mx1[30:0];
            hy2_reg  <= sh1 ? my1[31:1] : my1[30:0];
            am2x_reg <= 32'(ax1_reg[31] ? -34'(ax1_reg) : 34'(ax1_reg));
            am2y_reg <= 32'(ay1_reg[31] ? -34'(ay1_reg) : 34'(ay1_reg));
            an2x_reg <= ax1_reg[31];
            an2y_reg <= ay1_reg[31];
        end
    end

    // ---------------- stage 3: squares and a*dt^2 ----------------
    logic [61:0] sq3x_reg, sq3y_reg;
    logic [63:0] pa3x_reg, pa3y_reg;
    logic        an3x_reg, an3y_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            c3_reg   <= c2_reg;
            sq3x_reg <= 62'(hx2_reg) * 62'(hx2_reg);
            sq3y_reg <= 62'(hy2_reg) * 62'(hy2_reg);
            pa3x_reg <= 64'(am2x_reg) * 64'(dt2_reg);
            pa3y_reg <= 64'(am2y_reg) * 64'(dt2_reg);
            an3x_reg <= an2x_reg;
            an3y_reg <= an2y_reg;
        end
    end

    // ---------------- stage 4: sum of squares, rounded accel term ----------
    vsc_pkg::carry_t q_reg  [0:vsc_pkg::SQ_STEPS];
    logic [62:0]     sv_reg [0:vsc_pkg::SQ_STEPS];
    logic [63:0]     sr_reg [0:vsc_pkg::SQ_STEPS];
    logic [31:0]     tmx, tmy;
    vsc_pkg::carry_t q0_next;

    assign tmx = 32'((pa3x_reg + 64'h8000_0000) >> 32);
    assign tmy = 32'((pa3y_reg + 64'h8000_0000) >> 32);

    always_comb begin
        q0_next    = c3_reg;
        q0_next.tx = 32'(an3x_reg ? -$signed({1'b0, tmx}) : $signed({1'b0, tmx}));
        q0_next.ty = 32'(an3y_reg ? -$signed({1'b0, tmy}) : $signed({1'b0, tmy}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0]  <= q0_next;
            sv_reg[0] <= 63'(sq3x_reg) + 63'(sq3y_reg);
            sr_reg[0] <= '0;
        end
    end

    // ---------------- square root: one result bit per stage ----------------
    for (genvar k = 0; k < vsc_pkg::SQ_STEPS; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        logic        take;

        assign trial = sr_reg[k] + BIT;
        assign take  = {1'b0, sv_reg[k]} >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1] <= q_reg[k];
                if (take) begin
                    sv_reg[k+1] <= sv_reg[k] - trial[62:0];
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BIT;
                end else begin
                    sv_reg[k+1] <= sv_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
            end
        end
    end

    // ---------------- stage 5: distance, hit test, scale products ----------
    vsc_pkg::carry_t    cq, c5_next, c5_reg;
    logic [31:0]        root;
    logic [32:0]        dist5;
    logic [31:0]        lim_mag;
    logic [63:0]        pl5x_reg, pl5y_reg;

    assign cq      = q_reg[vsc_pkg::SQ_STEPS];
    assign root    = sr_reg[vsc_pkg::SQ_STEPS][31:0];
    assign dist5   = cq.sh ? {root, 1'b0} : {1'b0, root};
    assign lim_mag = 32'(cq.limit[31] ? -33'(cq.limit) : 33'(cq.limit));

    always_comb begin
        c5_next        = cq;
        c5_next.radial = dist5;
        c5_next.hit    = (dist5 != '0) && ($signed({1'b0, dist5}) > 34'(cq.limit));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c5_reg   <= c5_next;
            pl5x_reg <= 64'(cq.mx) * 64'(lim_mag);
            pl5y_reg <= 64'(cq.my) * 64'(lim_mag);
        end
    end

    // ---------------- stage 6: rounded numerators ----------------
    vsc_pkg::carry_t d_reg  [0:vsc_pkg::DIV_STEPS];
    vsc_pkg::div_t   dv_reg [0:vsc_pkg::DIV_STEPS][0:3];
    logic [63:0]     half;
    logic [63:0]     num6 [0:3];

    assign half    = 64'(c5_reg.radial[32:1]);
    assign num6[0] = pl5x_reg + half;
    assign num6[1] = pl5y_reg + half;
    assign num6[2] = {8'b0, c5_reg.mx, 24'b0} + half;
    assign num6[3] = {8'b0, c5_reg.my, 24'b0} + half;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= c5_reg;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_div_init
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[0][j].rem <= {3'b0, num6[j][63:33]};
                dv_reg[0][j].num <= num6[j];
                dv_reg[0][j].quo <= '0;
            end
        end
    end

    // ---------------- dividers: one quotient bit per stage ----------------
    for (genvar k = 0; k < vsc_pkg::DIV_STEPS; k++) begin : g_div
        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[k+1] <= d_reg[k];
            end
        end
        for (genvar j = 0; j < 4; j++) begin : g_lane
            logic [33:0] part;
            logic        ge;

            assign part = {dv_reg[k][j].rem[32:0], dv_reg[k][j].num[vsc_pkg::DIV_STEPS-1-k]};
            assign ge   = part >= {1'b0, d_reg[k].radial};

            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_reg[k+1][j].rem <= ge ? part - {1'b0, d_reg[k].radial} : part;
                    dv_reg[k+1][j].num <= dv_reg[k][j].num;
                    dv_reg[k+1][j].quo <= dv_reg[k][j].quo
                                        | (33'(ge) << (vsc_pkg::DIV_STEPS - 1 - k));
                end
            end
        end
    end

    // ---------------- E1: clamp onto the circle, signed normal ----------------
    vsc_pkg::carry_t    cd, e1_next, e1_reg, e2_reg, e3_reg, e4_reg, e5_reg, e6_reg;
    vsc_pkg::carry_t    e7_next, e7_reg;
    logic signed [33:0] svx, svy;
    logic [32:0]        qsx, qsy;
    logic [25:0]        qnx, qny;
    logic signed [26:0] nx1_reg, ny1_reg;

    assign cd  = d_reg[vsc_pkg::DIV_STEPS];
    assign qsx = dv_reg[vsc_pkg::DIV_STEPS][0].quo;
    assign qsy = dv_reg[vsc_pkg::DIV_STEPS][1].quo;
    assign qnx = dv_reg[vsc_pkg::DIV_STEPS][2].quo[25:0];
    assign qny = dv_reg[vsc_pkg::DIV_STEPS][3].quo[25:0];
    assign svx = (cd.neg_x ^ cd.limit[31]) ? -$signed({1'b0, qsx}) : $signed({1'b0, qsx});
    assign svy = (cd.neg_y ^ cd.limit[31]) ? -$signed({1'b0, qsy}) : $signed({1'b0, qsy});

    always_comb begin
        e1_next = cd;
        if (cd.hit) begin
            e1_next.cur_x = vsc_pkg::sat32(48'(cx_reg) + 48'(svx));
            e1_next.cur_y = vsc_pkg::sat32(48'(cy_reg) + 48'(svy));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg  <= e1_next;
            nx1_reg <= cd.neg_x ? -$signed({1'b0, qnx}) : $signed({1'b0, qnx});
            ny1_reg <= cd.neg_y ? -$signed({1'b0, qny}) : $signed({1'b0, qny});
        end
    end

    // ---------------- E2..E6: reflect the implied velocity ----------------
    logic signed [32:0] wx2_reg, wy2_reg, wx3_reg, wy3_reg, wx4_reg, wy4_reg;
    logic signed [32:0] wx5_reg, wy5_reg;
    logic signed [26:0] nx2_reg, ny2_reg, nx3_reg, ny3_reg, nx4_reg, ny4_reg;
    logic signed [59:0] mwx3_reg, mwy3_reg;
    logic signed [34:0] dot4_reg;
    logic signed [61:0] m2x5_reg, m2y5_reg;
    logic signed [39:0] rx6_reg, ry6_reg;
    logic signed [60:0] dsum;
    logic [60:0]        dsum_mag;
    logic [36:0]        dot_mag;
    logic [61:0]        pmx, pmy;
    logic [38:0]        rmx, rmy;

    assign dsum     = 61'(mwx3_reg) + 61'(mwy3_reg);
    assign dsum_mag = 61'(dsum[60] ? -dsum : dsum);
    assign dot_mag  = 37'((dsum_mag + 61'd8388608) >> 24);

    // 2*dot*n rounded at 2^24 equals dot*n rounded at 2^23
    assign pmx = 62'(m2x5_reg[61] ? -m2x5_reg : m2x5_reg);
    assign pmy = 62'(m2y5_reg[61] ? -m2y5_reg : m2y5_reg);
    assign rmx = 39'((pmx + 62'd4194304) >> 23);
    assign rmy = 39'((pmy + 62'd4194304) >> 23);

    always_ff @(posedge aclk) begin
        if (en) begin
            e2_reg   <= e1_reg;
            wx2_reg  <= 33'(e1_reg.cur_x) - 33'(e1_reg.prev_x);
            wy2_reg  <= 33'(e1_reg.cur_y) - 33'(e1_reg.prev_y);
            nx2_reg  <= nx1_reg;
            ny2_reg  <= ny1_reg;

            e3_reg   <= e2_reg;
            wx3_reg  <= wx2_reg;
            wy3_reg  <= wy2_reg;
            nx3_reg  <= nx2_reg;
            ny3_reg  <= ny2_reg;
            mwx3_reg <= 60'(wx2_reg) * 60'(nx2_reg);
            mwy3_reg <= 60'(wy2_reg) * 60'(ny2_reg);

            e4_reg   <= e3_reg;
            wx4_reg  <= wx3_reg;
            wy4_reg  <= wy3_reg;
            nx4_reg  <= nx3_reg;
            ny4_reg  <= ny3_reg;
            dot4_reg <= dsum[60] ? -$signed({1'b0, dot_mag[33:0]})
                                 : $signed({1'b0, dot_mag[33:0]});

            e5_reg   <= e4_reg;
            wx5_reg  <= wx4_reg;
            wy5_reg  <= wy4_reg;
            m2x5_reg <= 62'(dot4_reg) * 62'(nx4_reg);
            m2y5_reg <= 62'(dot4_reg) * 62'(ny4_reg);

            e6_reg   <= e5_reg;
            rx6_reg  <= 40'(wx5_reg) - (m2x5_reg[61] ? -$signed({1'b0, rmx})
                                                     : $signed({1'b0, rmx}));
            ry6_reg  <= 40'(wy5_reg) - (m2y5_reg[61] ? -$signed({1'b0, rmy})
                                                     : $signed({1'b0, rmy}));
        end
    end

    // ---------------- E7: reflected previous position ----------------
    always_comb begin
        e7_next = e6_reg;
        if (e6_reg.hit && bounce_reg) begin
            e7_next.prev_x = vsc_pkg::sat32(48'(e6_reg.cur_x) - 48'(rx6_reg));
            e7_next.prev_y = vsc_pkg::sat32(48'(e6_reg.cur_y) - 48'(ry6_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e7_reg <= e7_next;
        end
    end

    // ---------------- E8: position Verlet step ----------------
    vsc_pkg::out_t e8_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            e8_reg.cur_x  <= vsc_pkg::sat32(48'(e7_reg.cur_x) + 48'(e7_reg.cur_x)
                                            - 48'(e7_reg.prev_x) + 48'(e7_reg.tx));
            e8_reg.cur_y  <= vsc_pkg::sat32(48'(e7_reg.cur_y) + 48'(e7_reg.cur_y)
                                            - 48'(e7_reg.prev_y) + 48'(e7_reg.ty));
            e8_reg.prev_x <= e7_reg.cur_x;
            e8_reg.prev_y <= e7_reg.cur_y;
            e8_reg.hit    <= e7_reg.hit;
        end
    end

    assign last_data = e8_reg;

    // ---------------- checks ----------------
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register holds a transaction while the output is empty");

    a_frozen_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !s_tready) |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid register filled without a blocked output");

endmodule
